// ===== rtl/core/spte_pkg.sv =====
// ----------------------------------------------------------------------------
// spte_pkg
// Shared types and constants of the shortest path tree engine.
// ----------------------------------------------------------------------------
package spte_pkg;

    localparam int NODE_W    = 7;
    localparam int NIDX_W    = 6;
    localparam int MAX_NODES = 64;
    localparam int DIST_W    = 22;
    localparam int WT_W      = 16;
    localparam int RANK_W    = 6;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    typedef struct packed {
        logic [NODE_W-1:0] tail;
        logic [NODE_W-1:0] head;
        logic [WT_W-1:0]   wt;
    } edge_t;

    typedef struct packed {
        logic [DIST_W-1:0] path_len;
        logic [NODE_W-1:0] parent;
        logic [WT_W-1:0]   wt;
    } node_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SETTLE,
        ST_EDGE_RD,
        ST_EDGE_HEAD,
        ST_EDGE_UPD,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load_edge;
        logic start;
        logic scan_cmp;
        logic rescan;
        logic settle;
        logic sel_head;
        logic relax;
        logic out_load;
        logic out_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic v_last;
        logic pick_none;
        logic no_edges;
        logic e_last;
        logic out_taken;
    } stat_t;

endpackage

// ===== rtl/core/spte_if.sv =====
// ----------------------------------------------------------------------------
// spte_if
// Request and result channels of the shortest path tree engine.
// ----------------------------------------------------------------------------
interface spte_req_if;
    logic       valid;
    logic       ready;
    logic [0:0] kind;
    logic [6:0] from_node;
    logic [6:0] to_node;
    logic [15:0] weight;
    logic [6:0] start_node;

    modport source (output valid, kind, from_node, to_node, weight, start_node, input ready);
    modport sink   (input valid, kind, from_node, to_node, weight, start_node, output ready);
endinterface

interface spte_rsp_if;
    logic        valid;
    logic        ready;
    logic [6:0]  node;
    logic        reachable;
    logic [21:0] distance;
    logic [6:0]  parent;
    logic [15:0] tree_weight;
    logic [5:0]  settle_rank;
    logic        edges_dropped;
    logic        last;

    modport source (output valid, node, reachable, distance, parent, tree_weight,
                    settle_rank, edges_dropped, last, input ready);
    modport sink   (input valid, node, reachable, distance, parent, tree_weight,
                    settle_rank, edges_dropped, last, output ready);
endinterface

// ===== rtl/core/spte_dp.sv =====
// ----------------------------------------------------------------------------
// spte_dp
// Datapath: edge store, node memories, settle flags, counters, result register.
// ----------------------------------------------------------------------------
module spte_dp #(
    parameter int MAX_EDGES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spte_pkg::cmd_t       cmd,
    output spte_pkg::stat_t      stat,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_wdata,
    input  logic [6:0]           req_from,
    input  logic [6:0]           req_to,
    input  logic [15:0]          req_weight,
    input  logic [6:0]           req_start,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output logic [6:0]           rsp_node,
    output logic                 rsp_reachable,
    output logic [21:0]          rsp_distance,
    output logic [6:0]           rsp_parent,
    output logic [15:0]          rsp_tree_weight,
    output logic [5:0]           rsp_settle_rank,
    output logic                 rsp_edges_dropped,
    output logic                 rsp_last
);

    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NW     = spte_pkg::NODE_W;
    localparam int XW     = spte_pkg::NIDX_W;
    localparam int DW     = spte_pkg::DIST_W;
    localparam int MN     = spte_pkg::MAX_NODES;

    logic [NW-1:0]             node_count_reg;
    logic [NW-1:0]             n_eff;
    logic [ECNT_W-1:0]         edge_total_reg;
    logic                      drop_reg;
    logic [MN-1:0]             cand_reg;
    logic [MN-1:0]             done_reg;
    logic [NW-1:0]             v_cnt_reg;
    logic [NW-1:0]             pick_reg;
    logic [DW-1:0]             pick_dist_reg;
    logic [NW-1:0]             u_reg;
    logic [DW-1:0]             u_dist_reg;
    logic [spte_pkg::RANK_W-1:0] rank_cnt_reg;
    logic [ECNT_W-1:0]         e_cnt_reg;

    spte_pkg::edge_t           edge_mem [MAX_EDGES];
    spte_pkg::edge_t           edge_rd_reg;
    spte_pkg::node_word_t      node_mem [MN];
    spte_pkg::node_word_t      node_rd_reg;
    logic [spte_pkg::RANK_W-1:0] rank_mem [MN];
    logic [spte_pkg::RANK_W-1:0] rank_rd_reg;

    logic [NW-1:0]             v_m1, h_m1, p_m1, s_m1, rd_node, rd_m1;
    logic [XW-1:0]             v_idx, h_idx, p_idx, s_idx, rd_idx;
    logic                      edge_ok, src_ok, head_ok, better, upd;
    logic [DW-1:0]             dsum;
    spte_pkg::edge_t           edge_wdata;
    logic                      node_we;
    logic [XW-1:0]             node_waddr;
    spte_pkg::node_word_t      node_wdata;

    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = 7'd1;
        else if (node_count_reg > NW'(MN))
            n_eff = NW'(MN);
        else
            n_eff = node_count_reg;
    end

    assign v_m1  = v_cnt_reg - 7'd1;
    assign v_idx = v_m1[XW-1:0];
    assign h_m1  = edge_rd_reg.head - 7'd1;
    assign h_idx = h_m1[XW-1:0];
    assign p_m1  = pick_reg - 7'd1;
    assign p_idx = p_m1[XW-1:0];
    assign s_m1  = req_start - 7'd1;
    assign s_idx = s_m1[XW-1:0];

    assign edge_ok = (req_from != '0) && (req_from <= n_eff) &&
                     (req_to != '0) && (req_to <= n_eff) &&
                     (edge_total_reg < ECNT_W'(MAX_EDGES));
    assign src_ok  = (req_start != '0) && (req_start <= n_eff);
    assign edge_wdata = '{tail: req_from, head: req_to, wt: req_weight};

    // candidate comparison during the node scan
    assign better = cand_reg[v_idx] && !done_reg[v_idx] &&
                    ((pick_reg == '0) || (node_rd_reg.path_len < pick_dist_reg));

    // relaxation of one stored edge
    assign head_ok = (edge_rd_reg.tail == u_reg) && (edge_rd_reg.head != '0) &&
                     (edge_rd_reg.head <= n_eff) && !done_reg[h_idx];
    assign dsum    = u_dist_reg + DW'(edge_rd_reg.wt);
    assign upd     = head_ok && (!cand_reg[h_idx] || (dsum < node_rd_reg.path_len) ||
                     ((dsum == node_rd_reg.path_len) && (u_reg < node_rd_reg.parent)));

    assign rd_node = cmd.sel_head ? edge_rd_reg.head : v_cnt_reg;
    assign rd_m1   = rd_node - 7'd1;
    assign rd_idx  = rd_m1[XW-1:0];

    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = s_idx;
        node_wdata = '{path_len: '0, parent: req_start, wt: '0};
        if (cmd.start && src_ok)
        begin
            node_we = 1'b1;
        end
        else if (cmd.relax && upd)
        begin
            node_we    = 1'b1;
            node_waddr = h_idx;
            node_wdata = '{path_len: dsum, parent: u_reg, wt: edge_rd_reg.wt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_edge && edge_ok)
            edge_mem[edge_total_reg[EIDX_W-1:0]] <= edge_wdata;
        edge_rd_reg <= edge_mem[e_cnt_reg[EIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd_reg <= node_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.settle)
            rank_mem[p_idx] <= rank_cnt_reg;
        rank_rd_reg <= rank_mem[v_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= spte_pkg::NODE_COUNT_RST;
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
            cand_reg       <= '0;
            done_reg       <= '0;
            v_cnt_reg      <= 7'd1;
            pick_reg       <= '0;
            u_reg          <= '0;
            rank_cnt_reg   <= '0;
            e_cnt_reg      <= '0;
            rsp_valid      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                node_count_reg <= cfg_wdata;

            if (cmd.load_edge)
            begin
                if (edge_ok)
                    edge_total_reg <= edge_total_reg + ECNT_W'(1);
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                edge_total_reg <= '0;
                drop_reg       <= 1'b0;
            end

            if (cmd.start)
            begin
                // only the source starts as a candidate
                cand_reg     <= src_ok ? (MN'(1) << s_idx) : '0;
                done_reg     <= '0;
                v_cnt_reg    <= 7'd1;
                pick_reg     <= '0;
                rank_cnt_reg <= '0;
            end

            if (cmd.scan_cmp)
            begin
                if (better)
                    pick_reg <= v_cnt_reg;
                v_cnt_reg <= v_cnt_reg + 7'd1;
            end

            if (cmd.rescan)
            begin
                v_cnt_reg <= 7'd1;
                pick_reg  <= '0;
            end

            if (cmd.settle)
            begin
                done_reg[p_idx] <= 1'b1;
                u_reg           <= pick_reg;
                rank_cnt_reg    <= rank_cnt_reg + 6'd1;
                e_cnt_reg       <= '0;
            end

            if (cmd.relax)
            begin
                e_cnt_reg <= e_cnt_reg + ECNT_W'(1);
                if (upd)
                    cand_reg[h_idx] <= 1'b1;
            end

            if (cmd.out_next)
                v_cnt_reg <= v_cnt_reg + 7'd1;

            if (cmd.out_load)
                rsp_valid <= 1'b1;
            else if (rsp_valid && rsp_ready)
                rsp_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && better)
            pick_dist_reg <= node_rd_reg.path_len;
        if (cmd.settle)
            u_dist_reg <= pick_dist_reg;
        if (cmd.out_load)
        begin
            rsp_node          <= v_cnt_reg;
            rsp_reachable     <= done_reg[v_idx];
            rsp_distance      <= done_reg[v_idx] ? node_rd_reg.path_len : '0;
            rsp_parent        <= done_reg[v_idx] ? node_rd_reg.parent : '0;
            rsp_tree_weight   <= done_reg[v_idx] ? node_rd_reg.wt : '0;
            rsp_settle_rank   <= done_reg[v_idx] ? rank_rd_reg : '0;
            rsp_edges_dropped <= drop_reg;
            rsp_last          <= (v_cnt_reg == n_eff);
        end
    end

    assign stat.v_last    = (v_cnt_reg == n_eff);
    assign stat.pick_none = (pick_reg == '0);
    assign stat.no_edges  = (edge_total_reg == '0);
    assign stat.e_last    = ((e_cnt_reg + ECNT_W'(1)) == edge_total_reg);
    assign stat.out_taken = rsp_valid && rsp_ready;

endmodule

// ===== rtl/core/spte_ctrl.sv =====
// ----------------------------------------------------------------------------
// spte_ctrl
// Sequencer: node scan, settle, edge relaxation and result delivery.
// ----------------------------------------------------------------------------
module spte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_kind,
    output logic            req_ready,
    input  spte_pkg::stat_t stat,
    output spte_pkg::cmd_t  cmd
);

    spte_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spte_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            spte_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == spte_pkg::KIND_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = spte_pkg::ST_SCAN_RD;
                    end
                    else
                        cmd.load_edge = 1'b1;
                end
            end
            spte_pkg::ST_SCAN_RD:
                state_next = spte_pkg::ST_SCAN_CMP;
            spte_pkg::ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = stat.v_last ? spte_pkg::ST_SETTLE : spte_pkg::ST_SCAN_RD;
            end
            spte_pkg::ST_SETTLE:
            begin
                cmd.rescan = 1'b1;
                if (stat.pick_none)
                    state_next = spte_pkg::ST_OUT_RD;
                else
                begin
                    cmd.settle = 1'b1;
                    state_next = stat.no_edges ? spte_pkg::ST_SCAN_RD : spte_pkg::ST_EDGE_RD;
                end
            end
            spte_pkg::ST_EDGE_RD:
                state_next = spte_pkg::ST_EDGE_HEAD;
            spte_pkg::ST_EDGE_HEAD:
            begin
                cmd.sel_head = 1'b1;
                state_next   = spte_pkg::ST_EDGE_UPD;
            end
            spte_pkg::ST_EDGE_UPD:
            begin
                cmd.sel_head = 1'b1;
                cmd.relax    = 1'b1;
                state_next   = stat.e_last ? spte_pkg::ST_SCAN_RD : spte_pkg::ST_EDGE_RD;
            end
            spte_pkg::ST_OUT_RD:
                state_next = spte_pkg::ST_OUT_LD;
            spte_pkg::ST_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = spte_pkg::ST_OUT_WAIT;
            end
            spte_pkg::ST_OUT_WAIT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.v_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = spte_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = spte_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = spte_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/shortest_path_tree_engine_top.sv =====
// ----------------------------------------------------------------------------
// shortest_path_tree_engine_top
// Single source shortest path tree over a loaded edge list (Dijkstra).
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | request
//  req     | in  | kind, from_node, to_node, weight, start_node   | edge load or start
//  rsp     | out | node, reachable, distance, parent, tree_weight,| one per node
//          |     | settle_rank, edges_dropped, last               |
//  cfg     | in  | cfg_we, cfg_wdata (node_count)                 | register write
//
//  an edge load request is taken in ST_IDLE, and the engine stays ready after it
//  a start request runs a search: each settle round scans all nodes (SCAN_RD,
//  SCAN_CMP per node), then relaxes all stored edges (EDGE_RD, EDGE_HEAD,
//  EDGE_UPD per edge) through the single read port of the node
//  memory; each result then takes OUT_RD, OUT_LD and OUT_WAIT plus output stalls
//  no new request is taken until the last result of a search has been taken
//  reset is asynchronous active low; node_count resets to 64, edge store empty
// ----------------------------------------------------------------------------
module shortest_path_tree_engine_top #(
    parameter int MAX_EDGES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    spte_req_if.sink   req,
    spte_rsp_if.source rsp
);

    spte_pkg::cmd_t  cmd;
    spte_pkg::stat_t stat;

    // sequencer: owns the state machine and the request handshake
    spte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind[0]),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: memories, flags, counters and the result register
    spte_dp #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .req_from          (req.from_node),
        .req_to            (req.to_node),
        .req_weight        (req.weight),
        .req_start         (req.start_node),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_node          (rsp.node),
        .rsp_reachable     (rsp.reachable),
        .rsp_distance      (rsp.distance),
        .rsp_parent        (rsp.parent),
        .rsp_tree_weight   (rsp.tree_weight),
        .rsp_settle_rank   (rsp.settle_rank),
        .rsp_edges_dropped (rsp.edges_dropped),
        .rsp_last          (rsp.last)
    );

endmodule

// ===== verif/tb_shortest_path_tree_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_shortest_path_tree_engine_top
// Self-checking bench for the shortest path tree engine: edge loads and
// searches go in over the request channel, and every per-node result is
// compared with a behavioral Dijkstra kept inside the bench.
// ----------------------------------------------------------------------------
module tb_shortest_path_tree_engine_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_CAP   = 256;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 64;

    // one expected per-node result
    typedef struct {
        logic [6:0]  node;
        logic        reachable;
        logic [21:0] distance;
        logic [6:0]  parent;
        logic [15:0] tree_weight;
        logic [5:0]  settle_rank;
        logic        edges_dropped;
        logic        last;
    } node_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    spte_req_if req ();
    spte_rsp_if rsp ();

    shortest_path_tree_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // shadow of the engine state
    logic [6:0]  node_count_reg;
    logic [6:0]  edge_tail [EDGE_CAP];
    logic [6:0]  edge_head [EDGE_CAP];
    logic [15:0] edge_wt   [EDGE_CAP];
    int          edge_cnt;
    bit          drop_seen;

    node_result_t tree_results_q[$];

    int  fail_cnt;
    int  items_sent;
    int  searches_run;
    int  results_checked;
    int  reachable_seen;
    int  cycle_cnt;
    bit  send_idle_en;
    bit  recv_idle_en;
    int  hold_left;

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_CAP)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // the register clamps: 0 behaves as one node, above 64 as 64
    function automatic int active_nodes();
        if (node_count_reg < 1) return 1;
        if (node_count_reg > spte_pkg::MAX_NODES) return spte_pkg::MAX_NODES;
        return int'(node_count_reg);
    endfunction

    function automatic void store_edge(logic [6:0] a, logic [6:0] b, logic [15:0] w);
        int n;
        n = active_nodes();
        if (a < 1 || a > n || b < 1 || b > n || edge_cnt >= EDGE_CAP)
            drop_seen = 1'b1;
        else
        begin
            edge_tail[edge_cnt] = a;
            edge_head[edge_cnt] = b;
            edge_wt[edge_cnt]   = w;
            edge_cnt++;
        end
    endfunction

    // Dijkstra with the (distance, node, parent) tie order; queues one
    // result per node and empties the edge store afterwards
    function automatic void solve_tree(logic [6:0] src);
        longint best_d [spte_pkg::MAX_NODES+1];
        int     par    [spte_pkg::MAX_NODES+1];
        int     rnk    [spte_pkg::MAX_NODES+1];
        bit     cand   [spte_pkg::MAX_NODES+1];
        bit     done   [spte_pkg::MAX_NODES+1];
        int     n, rank, pick, u, v;
        longint d;
        node_result_t r;
        n = active_nodes();
        for (int i = 0; i <= spte_pkg::MAX_NODES; i++)
        begin
            best_d[i] = 0; par[i] = 0; rnk[i] = 0; cand[i] = 0; done[i] = 0;
        end
        rank = 0;
        if (src >= 1 && src <= n)
        begin
            cand[src] = 1;
            par[src]  = src;
            forever
            begin
                pick = 0;
                for (int i = 1; i <= n; i++)
                    if (cand[i] && !done[i] && (pick == 0 || best_d[i] < best_d[pick]))
                        pick = i;
                if (pick == 0) break;
                done[pick] = 1;
                rnk[pick]  = rank++;
                u = pick;
                for (int e = 0; e < edge_cnt; e++)
                begin
                    v = edge_head[e];
                    if (edge_tail[e] != u) continue;
                    if (v < 1 || v > n || edge_tail[e] > n) continue;
                    if (done[v]) continue;
                    d = best_d[u] + edge_wt[e];
                    if (!cand[v] || d < best_d[v] || (d == best_d[v] && u < par[v]))
                    begin
                        best_d[v] = d;
                        par[v]    = u;
                        cand[v]   = 1;
                    end
                end
            end
        end
        for (int i = 1; i <= n; i++)
        begin
            r.node          = 7'(i);
            r.reachable     = done[i];
            r.distance      = done[i] ? 22'(best_d[i]) : '0;
            r.parent        = done[i] ? 7'(par[i]) : '0;
            r.tree_weight   = done[i] ? 16'(best_d[i] - best_d[par[i]]) : '0;
            r.settle_rank   = done[i] ? 6'(rnk[i]) : '0;
            r.edges_dropped = drop_seen;
            r.last          = (i == n);
            tree_results_q  = {tree_results_q, r};
        end
        edge_cnt  = 0;
        drop_seen = 1'b0;
        searches_run++;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // random gap before a request, valid low while it lasts
    task automatic idle_gap();
        if (send_idle_en && $urandom_range(99) < 35)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_req(spte_pkg::kind_t k, logic [6:0] a, logic [6:0] b,
                            logic [15:0] w, logic [6:0] s);
        idle_gap();
        req.valid      <= 1'b1;
        req.kind       <= k;
        req.from_node  <= a;
        req.to_node    <= b;
        req.weight     <= w;
        req.start_node <= s;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        // request taken at this edge
        items_sent++;
        if (k == spte_pkg::KIND_LOAD)
            store_edge(a, b, w);
        else
            solve_tree(s);
    endtask

    task automatic load_edge(int a, int b, int w);
        send_req(spte_pkg::KIND_LOAD, 7'(a), 7'(b), 16'(w), 7'($urandom_range(127)));
    endtask

    task automatic start_search(int s);
        send_req(spte_pkg::KIND_START, 7'($urandom_range(127)), 7'($urandom_range(127)),
                 16'($urandom), 7'(s));
    endtask

    // register writes only once the engine has drained
    task automatic write_node_count(int val);
        req.valid <= 1'b0;
        while (tree_results_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 7'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_count_reg = 7'(val);
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern and checking
    // ------------------------------------------------------------------
    initial
    begin
        node_result_t x;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                if (tree_results_q.size() == 0)
                begin
                    $error("unexpected result for node %0d", rsp.node);
                    fail_cnt++;
                end
                else
                begin
                    x = tree_results_q.pop_front();
                    results_checked++;
                    if (x.reachable) reachable_seen++;
                    if (rsp.node !== x.node)
                        $error("node: expected %0d actual %0d", x.node, rsp.node);
                    if (rsp.reachable !== x.reachable)
                        $error("reachable: expected %0d actual %0d", x.reachable,
                               rsp.reachable);
                    if (rsp.distance !== x.distance)
                        $error("distance: expected %0d actual %0d", x.distance,
                               rsp.distance);
                    if (rsp.parent !== x.parent)
                        $error("parent: expected %0d actual %0d", x.parent, rsp.parent);
                    if (rsp.tree_weight !== x.tree_weight)
                        $error("tree_weight: expected %0d actual %0d", x.tree_weight,
                               rsp.tree_weight);
                    if (rsp.settle_rank !== x.settle_rank)
                        $error("settle_rank: expected %0d actual %0d", x.settle_rank,
                               rsp.settle_rank);
                    if (rsp.edges_dropped !== x.edges_dropped)
                        $error("edges_dropped: expected %0d actual %0d",
                               x.edges_dropped, rsp.edges_dropped);
                    if (rsp.last !== x.last)
                        $error("last: expected %0d actual %0d", x.last, rsp.last);
                    if (rsp.node !== x.node || rsp.reachable !== x.reachable ||
                        rsp.distance !== x.distance || rsp.parent !== x.parent ||
                        rsp.tree_weight !== x.tree_weight ||
                        rsp.settle_rank !== x.settle_rank ||
                        rsp.edges_dropped !== x.edges_dropped || rsp.last !== x.last)
                        fail_cnt++;
                end
            end
            // long hold-off first, then random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= !(recv_idle_en && $urandom_range(99) < 35);
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // small graph: shortcut beats direct edge, equal-distance tie, max weight
    task automatic test_basic_tree();
        write_node_count(6);
        load_edge(1, 2, 3);
        load_edge(1, 3, 1);
        load_edge(3, 2, 1);
        load_edge(3, 4, 1);
        load_edge(1, 4, 2);
        load_edge(2, 5, 65535);
        load_edge(5, 1, 0);
        start_search(1);
    endtask

    // edges naming node 0 or a node past the count are dropped and flagged;
    // a bad source leaves everything unreachable
    task automatic test_bad_edges_and_source();
        write_node_count(5);
        load_edge(0, 2, 7);
        load_edge(2, 0, 7);
        load_edge(6, 1, 7);
        load_edge(127, 127, 65535);
        load_edge(1, 2, 4);
        start_search(0);
        load_edge(1, 2, 4);
        start_search(127);
        load_edge(2, 3, 9);
        start_search(2);
    endtask

    // count lowered after loading: stored edges past the new count are ignored
    task automatic test_count_lowered();
        write_node_count(8);
        load_edge(1, 7, 1);
        load_edge(7, 2, 1);
        load_edge(1, 2, 5);
        load_edge(2, 3, 2);
        write_node_count(4);
        start_search(1);
    endtask

    // register extremes: 0 acts as one node, 127 as 64 nodes
    task automatic test_count_extremes();
        write_node_count(0);
        load_edge(1, 1, 3);
        start_search(1);
        write_node_count(127);
        for (int i = 64; i > 1; i--)
            load_edge(i, i - 1, 65535);
        load_edge(64, 1, 65535);
        start_search(64);
        write_node_count(64);
        load_edge(64, 63, 0);
        start_search(64);
    endtask

    // one edge past a full store is dropped
    task automatic test_store_full();
        write_node_count(4);
        for (int i = 0; i <= EDGE_CAP; i++)
            load_edge($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(20));
        start_search($urandom_range(1, 4));
    endtask

    // receiver holds off while more requests wait at the input
    task automatic test_result_backpressure();
        write_node_count(10);
        for (int i = 1; i < 10; i++)
            load_edge(i, i + 1, $urandom_range(1, 9));
        // long enough to outlast the search and stall the following loads
        hold_left = 3000;
        start_search(1);
        for (int i = 0; i < 4; i++)
            load_edge($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(50));
        start_search($urandom_range(1, 10));
    endtask

    // random graphs, mostly well formed, small counts, rare full-size ones
    task automatic test_random_graphs(int target);
        int n, ne, w;
        int first = items_sent;
        while (items_sent - first < target)
        begin
            // quiet stretch without any idling on either side
            send_idle_en = !((items_sent - first) inside {[30:70]});
            recv_idle_en = send_idle_en;
            if ($urandom_range(99) < 30)
            begin
                case ($urandom_range(19))
                    0:       write_node_count($urandom_range(65, 127));
                    1:       write_node_count(64);
                    2:       write_node_count(0);
                    default: write_node_count($urandom_range(1, 12));
                endcase
            end
            n  = active_nodes();
            ne = $urandom_range(0, (n > 12) ? 20 : 3 * n);
            for (int i = 0; i < ne; i++)
            begin
                w = $urandom_range(1) ? $urandom_range(4) : $urandom_range(65535);
                if ($urandom_range(99) < 8)
                    load_edge($urandom_range(127), $urandom_range(127), w);
                else
                    load_edge($urandom_range(1, n), $urandom_range(1, n), w);
            end
            if ($urandom_range(99) < 8)
                start_search($urandom_range(127));
            else
                start_search($urandom_range(1, n));
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_cnt        = 0;
        items_sent      = 0;
        searches_run    = 0;
        results_checked = 0;
        reachable_seen  = 0;
        hold_left       = 0;
        send_idle_en    = 1'b1;
        recv_idle_en    = 1'b1;
        node_count_reg  = spte_pkg::NODE_COUNT_RST;
        edge_cnt        = 0;
        drop_seen       = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req.valid       = 1'b0;
        req.kind        = spte_pkg::KIND_LOAD;
        req.from_node   = '0;
        req.to_node     = '0;
        req.weight      = '0;
        req.start_node  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_tree();
        test_bad_edges_and_source();
        test_count_lowered();
        test_count_extremes();
        test_store_full();
        test_result_backpressure();
        test_random_graphs(90);

        req.valid <= 1'b0;
        while (tree_results_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        fail_cnt += tree_results_q.size();

        $display("covered %0d requests, %0d searches, %0d node results (%0d reachable)",
                 items_sent, searches_run, results_checked, reachable_seen);
        $display("register extremes, dropped edges, full store and output stalls exercised");
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/spte_pkg.sv
rtl/core/spte_if.sv
rtl/core/spte_dp.sv
rtl/core/spte_ctrl.sv
rtl/core/shortest_path_tree_engine_top.sv
verif/tb_shortest_path_tree_engine_top.sv
